FILE: sv/assert_macros.svh
// assertion macros shared by the tile pattern expander modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRPE_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);
`define TRPE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define TRPE_ASSERT_IMPL(label, trig, cond, msg)
`define TRPE_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

FILE: sv/trpe_pkg.sv
// shared types, constants and helper functions of the tile pattern expander
`default_nettype none

package trpe_pkg;

    localparam int CHARACTERS      = 256;
    localparam int CHAR_W          = $clog2(CHARACTERS);
    localparam int TILE_MEM_BYTES  = 16384;
    localparam int ADDR_W          = $clog2(TILE_MEM_BYTES);
    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_W           = $clog2(PALETTE_ENTRIES);
    localparam int GRID_COLUMNS    = 16;
    localparam int GRID_W          = $clog2(GRID_COLUMNS);

    localparam int CMD_W   = 2;
    localparam int DATA_W  = 8;
    localparam int COLOR_W = 32;
    localparam int X_W     = 13;
    localparam int Y_W     = 9;

    localparam int WIDTH_W      = 6;
    localparam int HEIGHT_W     = 6;
    localparam int BPP_W        = 4;
    localparam int ROW_BYTES_W  = 7;
    localparam int TILE_BYTES_W = 13;
    localparam int PROD_W       = CHAR_W + WIDTH_W;
    localparam int PIX_W        = 3;

    localparam int DIV_W = ADDR_W;
    localparam int DVS_W = TILE_BYTES_W;
    localparam int CNT_W = $clog2(DIV_W);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TUSER_W = 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam int IN_DATA_LSB  = ADDR_W;
    localparam int IN_COLOR_LSB = ADDR_W + DATA_W;
    localparam int OUT_PAD_W    = M_TDATA_W - (X_W + Y_W + COLOR_W + DATA_W);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(8);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(8);
    localparam logic [BPP_W-1:0]    BPP_RESET    = BPP_W'(1);
    localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RESET  = ROW_BYTES_W'(1);
    localparam logic [TILE_BYTES_W-1:0] TILE_BYTES_RESET = TILE_BYTES_W'(8);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;
    localparam logic SURF_STRIP = 1'b0;
    localparam logic SURF_GRID  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_TILE = 2'd0,
        CMD_READ_TILE  = 2'd1,
        CMD_WRITE_PAL  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TILE_WIDTH  = 2'd0,
        REG_TILE_HEIGHT = 2'd1,
        REG_BPP         = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_CHECK,
        ST_READ,
        ST_DIV_CHAR,
        ST_DIV_ROW,
        ST_POS,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    // 2-bit channel level to 8-bit intensity
    function automatic logic [7:0] level8(input logic [1:0] lvl);
        logic [7:0] v;
        case (lvl)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h55;
            2'd2:    v = 8'hAA;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    // aarrggbb byte to argb word
    function automatic logic [COLOR_W-1:0] argb_from_byte(input logic [DATA_W-1:0] b);
        return {level8(b[7:6]), level8(b[5:4]), level8(b[3:2]), level8(b[1:0])};
    endfunction

    function automatic logic bpp_valid(input logic [BPP_W-1:0] bpp);
        return (bpp == BPP_W'(1)) || (bpp == BPP_W'(2)) ||
               (bpp == BPP_W'(4)) || (bpp == BPP_W'(8));
    endfunction

    // log2 of pixels per byte
    function automatic logic [1:0] pix_shift(input logic [BPP_W-1:0] bpp);
        logic [1:0] s;
        case (bpp)
            BPP_W'(1): s = 2'd3;
            BPP_W'(2): s = 2'd2;
            BPP_W'(4): s = 2'd1;
            default:   s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] pix_mask(input logic [BPP_W-1:0] bpp);
        logic [DATA_W-1:0] m;
        case (bpp)
            BPP_W'(1): m = 8'h01;
            BPP_W'(2): m = 8'h03;
            BPP_W'(4): m = 8'h0F;
            default:   m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/trpe_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"

module trpe_divider (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire trpe_pkg::div_req_t  req,
    output trpe_pkg::div_rsp_t       rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [trpe_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [trpe_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [trpe_pkg::DVS_W-1:0]    rem_reg, rem_next;
    logic [trpe_pkg::DVS_W-1:0]    dvs_reg, dvs_next;
    logic [trpe_pkg::DVS_W:0]      shifted;
    logic [trpe_pkg::DVS_W:0]      diff;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[trpe_pkg::DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[trpe_pkg::DIV_W-2:0], fits};
            rem_next = fits ? diff[trpe_pkg::DVS_W-1:0] : shifted[trpe_pkg::DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == trpe_pkg::CNT_W'(trpe_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `TRPE_ASSERT_IMPL(a_div_rem_below_divisor, done_reg, rem_reg < dvs_reg, "remainder not below divisor")
    `TRPE_ASSERT_IMPL(a_div_no_restart, req.start, !busy_reg, "divider restarted while busy")

endmodule

`default_nettype wire

FILE: sv/trpe_tile_ram.sv
// tile pattern memory with clearing pass after reset
`default_nettype none
`include "assert_macros.svh"

module trpe_tile_ram (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trpe_pkg::ram_req_t            req,
    output logic [trpe_pkg::DATA_W-1:0]        rdata,
    output logic                               clearing
);

    logic [trpe_pkg::DATA_W-1:0] mem [trpe_pkg::TILE_MEM_BYTES];
    logic [trpe_pkg::DATA_W-1:0] rdata_reg;
    logic                        clearing_reg, clearing_next;
    logic [trpe_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == trpe_pkg::ADDR_W'(trpe_pkg::TILE_MEM_BYTES - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

    `TRPE_ASSERT_IMPL(a_ram_idle_in_clear, req.wr || req.rd, !clearing_reg, "memory access during clearing")

endmodule

`default_nettype wire

FILE: sv/tile_ram_pixel_expander.sv
// top level: config registers, sequencer, palette and result register
//
// Tile pattern RAM with bitplane-to-pixel expansion.
// Slave stream s_*: one item per command (write tile byte, read tile byte,
// write palette entry). Master stream m_*: pixel results and read data,
// m_tlast marks the final result of an item. APB port holds tile width,
// tile height and bits per pixel at byte addresses 0, 4 and 8.
// One item is in work at a time; s_tready is low meanwhile.
// Each item passes ST_WAIT and ST_CHECK; a palette write ends in ST_CHECK,
// a read gives its result from ST_READ. A tile write in range at a legal
// depth then runs the shared restoring divider twice (character then row)
// at one quotient bit per cycle over 14 bits, and sends the pixel pairs at
// one result per cycle while the receiver does not stall.
// After reset the tile memory is cleared one byte a cycle while s_tready
// stays low; config writes are taken during that time.
// Palette resets to zero, registers to 8x8 tiles at 1 bit per pixel.
// A stalled receiver holds the result register and the sequencer waits;
// the next item is taken while the last result still waits in m_*.
`default_nettype none
`include "assert_macros.svh"

module tile_ram_pixel_expander (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_tdata: address[13:0], data_byte[21:14], palette_color[53:22], zero pad
    input  wire logic [trpe_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [trpe_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: pixel_x[12:0], pixel_y[21:13], color[53:22],
    // read_data[61:54], zero pad
    output logic [trpe_pkg::M_TDATA_W-1:0]         m_tdata,
    // m_tuser: kind[0], surface[1]
    output logic [trpe_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [trpe_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [trpe_pkg::PDATA_W-1:0]      pwdata,
    output logic [trpe_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    // config registers and derived tile geometry
    logic [trpe_pkg::WIDTH_W-1:0]      width_reg;
    logic [trpe_pkg::HEIGHT_W-1:0]     height_reg;
    logic [trpe_pkg::BPP_W-1:0]        bpp_reg;
    logic [trpe_pkg::ROW_BYTES_W-1:0]  row_bytes_reg, row_bytes_next;
    logic [trpe_pkg::TILE_BYTES_W-1:0] tile_bytes_reg, tile_bytes_next;
    logic                              cfg_wr;
    trpe_pkg::reg_idx_t                cfg_idx;

    // latched item
    logic [trpe_pkg::CMD_W-1:0]   cmd_reg;
    logic [trpe_pkg::ADDR_W-1:0]  addr_reg;
    logic [trpe_pkg::DATA_W-1:0]  data_reg;
    logic [trpe_pkg::COLOR_W-1:0] color_reg;
    logic                         s_accept;

    // sequencer
    trpe_pkg::seq_state_t             state_reg, state_next;
    logic [trpe_pkg::CHAR_W-1:0]      ch_reg, ch_next;
    logic [trpe_pkg::HEIGHT_W-1:0]    row_reg, row_next;
    logic [trpe_pkg::ROW_BYTES_W-1:0] col_reg, col_next;
    logic [trpe_pkg::X_W-1:0]         sx_reg, sx_next;
    logic [trpe_pkg::X_W-1:0]         gx_reg, gx_next;
    logic [trpe_pkg::Y_W-1:0]         gy_reg, gy_next;
    logic [trpe_pkg::PIX_W-1:0]       pix_left_reg, pix_left_next;
    logic                             surf_reg, surf_next;
    logic [trpe_pkg::DATA_W-1:0]      pat_reg, pat_next;
    logic                             rd_zero_reg, rd_zero_next;
    logic                             in_range;
    logic [trpe_pkg::X_W-1:0]         lx;
    logic [trpe_pkg::PAL_W-1:0]       pal_idx;
    logic                             pal_we;

    // palette
    logic [trpe_pkg::COLOR_W-1:0] pal_reg [trpe_pkg::PALETTE_ENTRIES];

    // shared units
    trpe_pkg::div_req_t          div_req;
    trpe_pkg::div_rsp_t          div_rsp;
    trpe_pkg::ram_req_t          ram_req;
    logic [trpe_pkg::DATA_W-1:0] ram_rdata;
    logic                        ram_clearing;

    // result register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         out_free, out_load;
    logic                         out_kind_reg, out_kind_next;
    logic                         out_surf_reg, out_surf_next;
    logic [trpe_pkg::X_W-1:0]     out_x_reg, out_x_next;
    logic [trpe_pkg::Y_W-1:0]     out_y_reg, out_y_next;
    logic [trpe_pkg::COLOR_W-1:0] out_color_reg, out_color_next;
    logic [trpe_pkg::DATA_W-1:0]  out_rdata_reg, out_rdata_next;
    logic                         out_last_reg, out_last_next;

    trpe_divider u_divider (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    trpe_tile_ram u_tile_ram (
        .clk (clk),
        .rst_n (rst_n),
        .req (ram_req),
        .rdata (ram_rdata),
        .clearing (ram_clearing)
    );

    // apb register file, writes land on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = trpe_pkg::reg_idx_t'(paddr[trpe_pkg::PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= trpe_pkg::WIDTH_RESET;
            height_reg <= trpe_pkg::HEIGHT_RESET;
            bpp_reg    <= trpe_pkg::BPP_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                trpe_pkg::REG_TILE_WIDTH:  width_reg  <= pwdata[trpe_pkg::WIDTH_W-1:0];
                trpe_pkg::REG_TILE_HEIGHT: height_reg <= pwdata[trpe_pkg::HEIGHT_W-1:0];
                trpe_pkg::REG_BPP:         bpp_reg    <= pwdata[trpe_pkg::BPP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            trpe_pkg::REG_TILE_WIDTH:  prdata = trpe_pkg::PDATA_W'(width_reg);
            trpe_pkg::REG_TILE_HEIGHT: prdata = trpe_pkg::PDATA_W'(height_reg);
            trpe_pkg::REG_BPP:         prdata = trpe_pkg::PDATA_W'(bpp_reg);
            default:                   prdata = '0;
        endcase
    end

    // bytes per tile row and per tile, one multiply per register
    assign row_bytes_next  = trpe_pkg::ROW_BYTES_W'(width_reg >> 3)
                           * trpe_pkg::ROW_BYTES_W'(bpp_reg);
    assign tile_bytes_next = trpe_pkg::TILE_BYTES_W'(row_bytes_reg)
                           * trpe_pkg::TILE_BYTES_W'(height_reg);

    // the memory holds CHARACTERS tiles, capped by its own size
    assign in_range = trpe_pkg::TILE_BYTES_W'(addr_reg >> trpe_pkg::CHAR_W) < tile_bytes_reg;

    assign s_tready = (state_reg == trpe_pkg::ST_IDLE) && !ram_clearing;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // local pixel column: byte column times pixels per byte, msb pixel leftmost
    assign lx      = (trpe_pkg::X_W'(col_reg) << trpe_pkg::pix_shift(bpp_reg))
                   + trpe_pkg::X_W'(pix_left_reg);
    assign pal_idx = trpe_pkg::PAL_W'(pat_reg & trpe_pkg::pix_mask(bpp_reg));

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        sx_next        = sx_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        pix_left_next  = pix_left_reg;
        surf_next      = surf_reg;
        pat_next       = pat_reg;
        rd_zero_next   = rd_zero_reg;
        pal_we         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = addr_reg;
        div_req.divisor  = tile_bytes_reg;
        ram_req.wr     = 1'b0;
        ram_req.rd     = 1'b0;
        ram_req.addr   = addr_reg;
        ram_req.wdata  = data_reg;
        out_load       = 1'b0;
        out_kind_next  = trpe_pkg::KIND_PIXEL;
        out_surf_next  = surf_reg;
        out_x_next     = (surf_reg == trpe_pkg::SURF_GRID) ? gx_reg + lx : sx_reg + lx;
        out_y_next     = (surf_reg == trpe_pkg::SURF_GRID) ? gy_reg
                                                            : trpe_pkg::Y_W'(row_reg);
        out_color_next = (bpp_reg == trpe_pkg::BPP_W'(8)) ? trpe_pkg::argb_from_byte(pat_reg)
                                                           : pal_reg[pal_idx];
        out_rdata_next = '0;
        out_last_next  = (surf_reg == trpe_pkg::SURF_GRID) && (pix_left_reg == '0);

        case (state_reg)
            trpe_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = trpe_pkg::ST_WAIT;
                end
            end
            // let the geometry registers settle after a config write
            trpe_pkg::ST_WAIT:
            begin
                state_next = trpe_pkg::ST_CHECK;
            end
            trpe_pkg::ST_CHECK:
            begin
                state_next = trpe_pkg::ST_IDLE;
                case (cmd_reg)
                    trpe_pkg::CMD_WRITE_TILE:
                    begin
                        if (in_range)
                        begin
                            ram_req.wr = 1'b1;
                            if (trpe_pkg::bpp_valid(bpp_reg))
                            begin
                                div_req.start = 1'b1;
                                state_next    = trpe_pkg::ST_DIV_CHAR;
                            end
                        end
                    end
                    trpe_pkg::CMD_READ_TILE:
                    begin
                        ram_req.rd   = in_range;
                        rd_zero_next = !in_range;
                        state_next   = trpe_pkg::ST_READ;
                    end
                    trpe_pkg::CMD_WRITE_PAL:
                    begin
                        pal_we = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            trpe_pkg::ST_READ:
            begin
                out_kind_next  = trpe_pkg::KIND_READ;
                out_surf_next  = trpe_pkg::SURF_STRIP;
                out_x_next     = '0;
                out_y_next     = '0;
                out_color_next = '0;
                out_rdata_next = rd_zero_reg ? '0 : ram_rdata;
                out_last_next  = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = trpe_pkg::ST_IDLE;
                end
            end
            // character and byte offset within the tile
            trpe_pkg::ST_DIV_CHAR:
            begin
                if (div_rsp.done)
                begin
                    ch_next          = div_rsp.quotient[trpe_pkg::CHAR_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = trpe_pkg::DIV_W'(div_rsp.remainder);
                    div_req.divisor  = trpe_pkg::DVS_W'(row_bytes_reg);
                    state_next       = trpe_pkg::ST_DIV_ROW;
                end
            end
            // pixel row and byte column
            trpe_pkg::ST_DIV_ROW:
            begin
                if (div_rsp.done)
                begin
                    row_next   = div_rsp.quotient[trpe_pkg::HEIGHT_W-1:0];
                    col_next   = div_rsp.remainder[trpe_pkg::ROW_BYTES_W-1:0];
                    state_next = trpe_pkg::ST_POS;
                end
            end
            // surface origins of the character
            trpe_pkg::ST_POS:
            begin
                sx_next = trpe_pkg::X_W'(trpe_pkg::PROD_W'(ch_reg)
                                       * trpe_pkg::PROD_W'(width_reg));
                gx_next = trpe_pkg::X_W'(trpe_pkg::PROD_W'(ch_reg[trpe_pkg::GRID_W-1:0])
                                       * trpe_pkg::PROD_W'(width_reg));
                gy_next = trpe_pkg::Y_W'(trpe_pkg::PROD_W'(ch_reg[trpe_pkg::CHAR_W-1:trpe_pkg::GRID_W])
                                       * trpe_pkg::PROD_W'(height_reg)
                                       + trpe_pkg::PROD_W'(row_reg));
                pix_left_next = trpe_pkg::PIX_W'((4'd1 << trpe_pkg::pix_shift(bpp_reg)) - 4'd1);
                surf_next     = trpe_pkg::SURF_STRIP;
                pat_next      = data_reg;
                state_next    = trpe_pkg::ST_EMIT;
            end
            // one result per cycle while the result register is free, strip then grid for each pixel
            trpe_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    surf_next = !surf_reg;
                    if (surf_reg == trpe_pkg::SURF_GRID)
                    begin
                        pix_left_next = pix_left_reg - 1'b1;
                        pat_next      = pat_reg >> bpp_reg;
                    end
                    if (out_last_next)
                    begin
                        state_next = trpe_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = trpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trpe_pkg::ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            row_bytes_reg  <= trpe_pkg::ROW_BYTES_RESET;
            tile_bytes_reg <= trpe_pkg::TILE_BYTES_RESET;
            for (int i = 0; i < trpe_pkg::PALETTE_ENTRIES; i++)
            begin
                pal_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            row_bytes_reg  <= row_bytes_next;
            tile_bytes_reg <= tile_bytes_next;
            if (pal_we)
            begin
                pal_reg[addr_reg[trpe_pkg::PAL_W-1:0]] <= color_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg   <= s_tuser[trpe_pkg::CMD_W-1:0];
            addr_reg  <= s_tdata[trpe_pkg::ADDR_W-1:0];
            data_reg  <= s_tdata[trpe_pkg::IN_DATA_LSB +: trpe_pkg::DATA_W];
            color_reg <= s_tdata[trpe_pkg::IN_COLOR_LSB +: trpe_pkg::COLOR_W];
        end
        ch_reg       <= ch_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        sx_reg       <= sx_next;
        gx_reg       <= gx_next;
        gy_reg       <= gy_next;
        pix_left_reg <= pix_left_next;
        surf_reg     <= surf_next;
        pat_reg      <= pat_next;
        rd_zero_reg  <= rd_zero_next;
        if (out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_surf_reg  <= out_surf_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_color_reg <= out_color_next;
            out_rdata_reg <= out_rdata_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{trpe_pkg::OUT_PAD_W{1'b0}}, out_rdata_reg, out_color_reg,
                       out_y_reg, out_x_reg};
    assign m_tuser  = {out_surf_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    `TRPE_ASSERT_NEXT(a_last_ends_item, out_load && out_last_next, state_reg == trpe_pkg::ST_IDLE, "sequencer busy after last result")
    `TRPE_ASSERT_IMPL(a_div_done_in_div_state, div_rsp.done, (state_reg == trpe_pkg::ST_DIV_CHAR) || (state_reg == trpe_pkg::ST_DIV_ROW), "divider result outside divide states")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// testbench for the tile pattern expander: directed and random streams checked against a predictor
`timescale 1ns / 100ps

module tb_top;

    import trpe_pkg::*;

    // command 3 has no function in the block and must be ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // slowest legal run: the clearing pass, then about 250 items, each with up to
    // 16 results under heavy stalls; the limit is far above that
    localparam int CYCLE_LIMIT  = 600000;
    // longest item in work (tile write at 1 bpp) plus margin
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic               kind;
        logic               surface;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] color;
        logic [DATA_W-1:0]  rdata;
        logic               last;
    } pixel_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // s_tdata: address[13:0], data_byte[21:14], palette_color[53:22], zero pad
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // s_tuser: command[1:0]
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // m_tdata: pixel_x[12:0], pixel_y[21:13], color[53:22], read_data[61:54]
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: kind[0], surface[1]
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // predictor state: shadow of the tile ram, the palette and the registers
    logic [DATA_W-1:0]   shadow_tiles [TILE_MEM_BYTES];
    logic [COLOR_W-1:0]  shadow_palette [PALETTE_ENTRIES];
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [BPP_W-1:0]    cfg_bpp;

    // results predicted but not yet seen on the master stream
    pixel_out_t pending_outputs[$];
    // tile addresses written so far, used to aim reads at stored bytes
    int unsigned written_addrs[$];

    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    tile_ram_pixel_expander i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_outputs.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure, random per cycle at the current stall rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // bytes of tile memory that the current geometry covers
    function automatic int unsigned active_bytes();
        int unsigned row_bytes;
        int unsigned tile_bytes;
        int unsigned total;
        row_bytes  = (int'(cfg_width) >> 3) * int'(cfg_bpp);
        tile_bytes = row_bytes * int'(cfg_height);
        total      = CHARACTERS * tile_bytes;
        return (total < TILE_MEM_BYTES) ? total : TILE_MEM_BYTES;
    endfunction

    // 2-bit channel level scaled to 8 bits by replicating it
    function automatic logic [7:0] channel_scale(input logic [1:0] lvl);
        return {4{lvl}};
    endfunction

    // one pixel goes out twice: strip surface first, then the 16-wide grid
    function automatic void push_pixel_pair(input int unsigned ch, input int unsigned lx,
                                            input int unsigned row,
                                            input logic [COLOR_W-1:0] color);
        pixel_out_t r;
        int unsigned sx;
        int unsigned gx;
        int unsigned gy;
        sx = ch * int'(cfg_width) + lx;
        gx = (ch % GRID_COLUMNS) * int'(cfg_width) + lx;
        gy = (ch / GRID_COLUMNS) * int'(cfg_height) + row;
        r.kind    = KIND_PIXEL;
        r.rdata   = '0;
        r.last    = 1'b0;
        r.color   = color;
        // positions wrap to the port widths
        r.surface = SURF_STRIP;
        r.x       = sx[X_W-1:0];
        r.y       = row[Y_W-1:0];
        pending_outputs.push_back(r);
        r.surface = SURF_GRID;
        r.x       = gx[X_W-1:0];
        r.y       = gy[Y_W-1:0];
        pending_outputs.push_back(r);
    endfunction

    // updates the shadow state for one accepted item and queues its results
    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data,
                                            input logic [COLOR_W-1:0] color);
        int unsigned row_bytes;
        int unsigned tile_bytes;
        int unsigned ch;
        int unsigned offs;
        int unsigned col;
        int unsigned row;
        int unsigned per_byte;
        int unsigned idx;
        int queued;
        pixel_out_t rd;
        row_bytes  = (int'(cfg_width) >> 3) * int'(cfg_bpp);
        tile_bytes = row_bytes * int'(cfg_height);
        queued     = pending_outputs.size();
        case (cmd)
            CMD_WRITE_TILE:
            begin
                // writes beyond the covered area are dropped entirely
                if (int'(addr) < active_bytes())
                begin
                    shadow_tiles[addr] = data;
                    ch   = addr / tile_bytes;
                    offs = addr % tile_bytes;
                    col  = offs % row_bytes;
                    row  = offs / row_bytes;
                    if (cfg_bpp == 4'd8)
                        push_pixel_pair(ch, col, row,
                                        {channel_scale(data[7:6]), channel_scale(data[5:4]),
                                         channel_scale(data[3:2]), channel_scale(data[1:0])});
                    else if (cfg_bpp == 4'd1 || cfg_bpp == 4'd2 || cfg_bpp == 4'd4)
                    begin
                        // pixel 0 sits in the low bits but is the rightmost on screen
                        per_byte = 8 / int'(cfg_bpp);
                        for (int unsigned i = 0; i < per_byte; i++)
                        begin
                            idx = (int'(data) >> (i * cfg_bpp)) & ((1 << cfg_bpp) - 1);
                            push_pixel_pair(ch, col * per_byte + (per_byte - 1 - i), row,
                                            shadow_palette[idx % PALETTE_ENTRIES]);
                        end
                    end
                    if (pending_outputs.size() > queued)
                        pending_outputs[pending_outputs.size() - 1].last = 1'b1;
                end
            end
            CMD_READ_TILE:
            begin
                rd.kind    = KIND_READ;
                rd.surface = SURF_STRIP;
                rd.x       = '0;
                rd.y       = '0;
                rd.color   = '0;
                rd.rdata   = (int'(addr) < active_bytes()) ? shadow_tiles[addr] : '0;
                rd.last    = 1'b1;
                pending_outputs.push_back(rd);
            end
            CMD_WRITE_PAL:
                shadow_palette[addr[PAL_W-1:0]] = color;
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                compare_field("kind", want.kind, m_tuser[0]);
                compare_field("surface", want.surface, m_tuser[1]);
                compare_field("pixel_x", want.x, m_tdata[12:0]);
                compare_field("pixel_y", want.y, m_tdata[21:13]);
                compare_field("color", want.color, m_tdata[53:22]);
                compare_field("read_data", want.rdata, m_tdata[61:54]);
                compare_field("last", want.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offers one item, waits for it to be taken, then maybe leaves a gap
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [COLOR_W-1:0] color);
        s_tdata  <= {2'b00, color, data, addr};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_command(cmd, addr, data, color);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop offering, wait for every result, then give a silent item time to finish
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write with a back-to-back read of the same register
    task automatic set_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] stored;
        case (idx)
            REG_TILE_WIDTH:  stored = {26'd0, value[WIDTH_W-1:0]};
            REG_TILE_HEIGHT: stored = {26'd0, value[HEIGHT_W-1:0]};
            default:         stored = {28'd0, value[BPP_W-1:0]};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_TILE_WIDTH:  cfg_width  = value[WIDTH_W-1:0];
            REG_TILE_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
            default:         cfg_bpp    = value[BPP_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        compare_field("register readback", stored, prdata);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int bpp);
        set_register(REG_TILE_WIDTH, w);
        set_register(REG_TILE_HEIGHT, h);
        set_register(REG_BPP, bpp);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset geometry: 8x8 tiles at 1 bpp, 2048 bytes covered
    task automatic test_default_geometry();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // high address bits of a palette write are ignored
        send_item(CMD_WRITE_PAL, 14'h3FF1, 8'h00, 32'hFFFF_FFFF);
        send_item(CMD_WRITE_PAL, 14'h0000, 8'h00, 32'h8000_0001);
        // msb pixel lands leftmost
        send_item(CMD_WRITE_TILE, 14'd0, 8'h80, 32'h0);
        send_item(CMD_READ_TILE, 14'd0, 8'h00, 32'h0);
        // last covered byte: character 255, bottom row
        send_item(CMD_WRITE_TILE, 14'd2047, 8'hFF, 32'h0);
        // first byte beyond the covered area is dropped and reads as zero
        send_item(CMD_WRITE_TILE, 14'd2048, 8'h5A, 32'h0);
        send_item(CMD_READ_TILE, 14'd2048, 8'h00, 32'h0);
        send_item(CMD_READ_TILE, 14'd16383, 8'h00, 32'h0);
        send_item(CMD_UNUSED, 14'd5, 8'hA5, 32'hFFFF_FFFF);
        send_item(CMD_WRITE_TILE, 14'd9, 8'h01, 32'h0);
        send_item(CMD_READ_TILE, 14'd2047, 8'h00, 32'h0);
        settle_idle();
    endtask

    // the legal depths 2, 4 and 8 once each, and one depth that produces no pixels
    task automatic test_color_depths();
        set_register(REG_BPP, 2);
        send_item(CMD_WRITE_PAL, 14'h000F, 8'h00, 32'hDEAD_BEEF);
        send_item(CMD_WRITE_TILE, 14'd3, 8'hE4, 32'h0);
        settle_idle();
        set_register(REG_BPP, 4);
        send_item(CMD_WRITE_TILE, 14'd31, 8'hF0, 32'h0);
        settle_idle();
        // direct argb from 2-bit channels, whole memory covered
        set_register(REG_BPP, 8);
        send_item(CMD_WRITE_TILE, 14'd16383, 8'hE4, 32'h0);
        send_item(CMD_WRITE_TILE, 14'd0, 8'h1B, 32'h0);
        send_item(CMD_READ_TILE, 14'd16383, 8'h00, 32'h0);
        settle_idle();
        // odd depth: byte is stored silently
        set_register(REG_BPP, 3);
        send_item(CMD_WRITE_TILE, 14'd5, 8'h3C, 32'h0);
        send_item(CMD_READ_TILE, 14'd5, 8'h00, 32'h0);
        settle_idle();
    endtask

    // empty tile, then geometries whose positions wrap at the port widths
    task automatic test_degenerate_tiles();
        // narrower than one byte: nothing is covered
        set_geometry(4, 8, 1);
        send_item(CMD_WRITE_TILE, 14'd0, 8'h77, 32'h0);
        send_item(CMD_READ_TILE, 14'd0, 8'h00, 32'h0);
        settle_idle();
        // strip x wraps past 8191
        set_geometry(56, 15, 1);
        send_item(CMD_WRITE_TILE, 14'd16379, 8'hC3, 32'h0);
        settle_idle();
        // grid y wraps past 511
        set_geometry(8, 40, 1);
        send_item(CMD_WRITE_TILE, 14'd10239, 8'h96, 32'h0);
        settle_idle();
    endtask

    // random traffic at one geometry and one idling pattern
    task automatic test_random_traffic(input int w, input int h, input int bpp, input int items,
                                       input int idle_pct, input int stall_pct);
        int unsigned pick;
        int unsigned span;
        logic [ADDR_W-1:0] addr;
        set_geometry(w, h, bpp);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        span = active_bytes();
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_item(CMD_WRITE_PAL, $urandom_range(16383), $urandom_range(255), $urandom);
            else if (pick < 60)
            begin
                addr = $urandom_range(span - 1);
                written_addrs.push_back(addr);
                if (written_addrs.size() > 64)
                    void'(written_addrs.pop_front());
                send_item(CMD_WRITE_TILE, addr, $urandom_range(255), $urandom);
            end
            else if (pick < 85)
            begin
                if (written_addrs.size() != 0 && $urandom_range(1) == 1)
                    addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
                else
                    addr = $urandom_range(16383);
                send_item(CMD_READ_TILE, addr, $urandom_range(255), $urandom);
            end
            else if (pick < 93)
                // anywhere, often beyond the covered area
                send_item(CMD_WRITE_TILE, $urandom_range(16383), $urandom_range(255), $urandom);
            else
                send_item(CMD_UNUSED, $urandom_range(16383), $urandom_range(255), $urandom);
        end
        settle_idle();
    endtask

    initial
    begin
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        cfg_bpp    = BPP_RESET;
        for (int i = 0; i < TILE_MEM_BYTES; i++)
            shadow_tiles[i] = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            shadow_palette[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block clears its ram after reset; s_tready stays low meanwhile
        test_default_geometry();
        test_color_depths();
        test_degenerate_tiles();

        test_random_traffic(8, 8, 1, 30, 0, 0);
        test_random_traffic(32, 32, 8, 30, 59, 0);
        test_random_traffic(16, 1, 2, 30, 0, 59);
        test_random_traffic(24, 5, 4, 30, 28, 28);
        test_random_traffic(32, 16, 1, 30, 0, 0);
        test_random_traffic(8, 32, 7, 30, 28, 28);
        test_random_traffic(8, 1, 1, 30, 59, 59);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
